// ----- rtl/pbsc_pkg.sv -----
// Package: shared types, constants and codes for the slot cache manager.
`default_nettype none
package pbsc_pkg;
  localparam int NumSlotsDef   = 16;
  localparam int SlotBytesDef  = 2048;
  localparam int CacheBytesDef = 4096;
  localparam int AlignBytesDef = 16;

  localparam int SizeW  = 12;
  localparam int SlotInW = 15;
  localparam int OffW   = 12;
  localparam int SlotOW = 4;
  localparam int CntW   = 5;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_ACCESS = 2'd2,
    REQ_BAD    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_INVALID  = 2'd2,
    ST_NO_CACHE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FIT_INIT, S_FIT_SCAN, S_FIT_DONE, S_EVICT,
    S_COMMIT, S_OUT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;    // capture request
    logic decode;      // evaluate request, pick slot
    logic fit_init;    // reset first-fit search
    logic fit_step;    // one blocker scan step
    logic evict;       // evict lowest cached slot
    logic commit;      // apply state update and form result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_fit;    // request requires placement
    logic fit_done;    // search finished
    logic fit_ok;      // search found a place
    logic is_miss;     // access miss (eviction allowed)
    logic evict_done;  // eviction already tried
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/packet_buffer_slot_cache_manager_unit.sv -----
// Top level: packet buffer slot cache manager, controller plus datapath.
// Flow: the request is captured, decoded, placed by a first-fit scan where needed (an
// evicting miss evicts the lowest cached slot and scans again), committed and then
// presented with out_valid_o.
// One request at a time: the result holds until taken, then the next request enters.
// Reset (rst_ni, async low) empties the slot table and zeroes the counters.
`default_nettype none
module packet_buffer_slot_cache_manager_unit #(
  parameter int NUM_SLOTS   = pbsc_pkg::NumSlotsDef,
  parameter int SLOT_BYTES  = pbsc_pkg::SlotBytesDef,
  parameter int CACHE_BYTES = pbsc_pkg::CacheBytesDef,
  parameter int ALIGN_BYTES = pbsc_pkg::AlignBytesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [pbsc_pkg::SizeW-1:0]   req_size_i,
  input  wire logic                         want_cache_i,
  input  wire logic                         by_offset_i,
  input  wire logic [pbsc_pkg::SlotInW-1:0] slot_in_i,
  input  wire logic [pbsc_pkg::OffW-1:0]    offset_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        status_o,
  output logic [pbsc_pkg::SlotOW-1:0]       slot_out_o,
  output logic                              in_cache_o,
  output logic [pbsc_pkg::OffW-1:0]         cache_offset_o,
  output logic [pbsc_pkg::SizeW-1:0]        length_o,
  output logic                              hit_o,
  output logic                              load_needed_o,
  output logic                              evicted_o,
  output logic [pbsc_pkg::SlotOW-1:0]       evicted_slot_o,
  output logic [pbsc_pkg::OffW-1:0]         evicted_offset_o,
  output logic [pbsc_pkg::CntW-1:0]         cached_count_o,
  output logic [pbsc_pkg::CntW-1:0]         backing_count_o
);
  pbsc_pkg::cmd_t cmd;
  pbsc_pkg::sts_t sts;

  pbsc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pbsc_dpath #(
    .NUM_SLOTS(NUM_SLOTS), .SLOT_BYTES(SLOT_BYTES),
    .CACHE_BYTES(CACHE_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
  ) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i, .req_size_i, .want_cache_i, .by_offset_i, .slot_in_i, .offset_in_i,
    .status_o, .slot_out_o, .in_cache_o, .cache_offset_o, .length_o, .hit_o,
    .load_needed_o, .evicted_o, .evicted_slot_o, .evicted_offset_o,
    .cached_count_o, .backing_count_o
  );
endmodule
`default_nettype wire

// ----- rtl/pbsc_ctrl.sv -----
// Controller state machine sequencing decode, first-fit search, eviction, commit and result output.
`default_nettype none
module pbsc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire pbsc_pkg::sts_t sts_i,
  output pbsc_pkg::cmd_t     cmd_o
);
  pbsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pbsc_pkg::S_IDLE;
    else state_q <= state_d;
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      pbsc_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = pbsc_pkg::S_DECODE;
        end
      end
      pbsc_pkg::S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d = pbsc_pkg::S_FIT_INIT;
      end
      pbsc_pkg::S_FIT_INIT: begin
        if (sts_i.need_fit) begin
          cmd_o.fit_init = 1'b1;
          state_d = pbsc_pkg::S_FIT_SCAN;
        end else begin
          state_d = pbsc_pkg::S_COMMIT;
        end
      end
      pbsc_pkg::S_FIT_SCAN: begin
        if (sts_i.fit_done) state_d = pbsc_pkg::S_FIT_DONE;
        else cmd_o.fit_step = 1'b1;
      end
      pbsc_pkg::S_FIT_DONE: begin
        if (!sts_i.fit_ok && sts_i.is_miss && !sts_i.evict_done)
          state_d = pbsc_pkg::S_EVICT;
        else state_d = pbsc_pkg::S_COMMIT;
      end
      pbsc_pkg::S_EVICT: begin
        cmd_o.evict    = 1'b1;
        cmd_o.fit_init = 1'b1;
        state_d = pbsc_pkg::S_FIT_SCAN;
      end
      pbsc_pkg::S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = pbsc_pkg::S_OUT;
      end
      pbsc_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = pbsc_pkg::S_IDLE;
      end
      default: state_d = pbsc_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == pbsc_pkg::S_OUT) else $error("out valid outside S_OUT");
  a_commit_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o) else $error("commit not followed by result");
  a_evict_rescan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.evict |=> state_q == pbsc_pkg::S_FIT_SCAN) else $error("evict without rescan");
`endif
endmodule
`default_nettype wire

// ----- rtl/pbsc_dpath.sv -----
// Datapath: slot table, first-fit search unit, counters and result register.
`default_nettype none
module pbsc_dpath #(
  parameter int NUM_SLOTS   = pbsc_pkg::NumSlotsDef,
  parameter int SLOT_BYTES  = pbsc_pkg::SlotBytesDef,
  parameter int CACHE_BYTES = pbsc_pkg::CacheBytesDef,
  parameter int ALIGN_BYTES = pbsc_pkg::AlignBytesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pbsc_pkg::cmd_t               cmd_i,
  output pbsc_pkg::sts_t                    sts_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [pbsc_pkg::SizeW-1:0]   req_size_i,
  input  wire logic                         want_cache_i,
  input  wire logic                         by_offset_i,
  input  wire logic [pbsc_pkg::SlotInW-1:0] slot_in_i,
  input  wire logic [pbsc_pkg::OffW-1:0]    offset_in_i,
  output logic [1:0]                        status_o,
  output logic [pbsc_pkg::SlotOW-1:0]       slot_out_o,
  output logic                              in_cache_o,
  output logic [pbsc_pkg::OffW-1:0]         cache_offset_o,
  output logic [pbsc_pkg::SizeW-1:0]        length_o,
  output logic                              hit_o,
  output logic                              load_needed_o,
  output logic                              evicted_o,
  output logic [pbsc_pkg::SlotOW-1:0]       evicted_slot_o,
  output logic [pbsc_pkg::OffW-1:0]         evicted_offset_o,
  output logic [pbsc_pkg::CntW-1:0]         cached_count_o,
  output logic [pbsc_pkg::CntW-1:0]         backing_count_o
);
  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW  = $clog2(NUM_SLOTS + 1);
  localparam int PW  = $clog2(CACHE_BYTES + SLOT_BYTES + 1) + 1;
  localparam int AW  = $clog2(ALIGN_BYTES);
  localparam int LW  = pbsc_pkg::SizeW + 1;
  localparam int IW  = $clog2(NUM_SLOTS + 2);
  localparam logic [PW-1:0] CacheTop = PW'(CACHE_BYTES);

  // Slot table
  logic [NUM_SLOTS-1:0] used_q, cached_q;
  logic [LW-1:0]        len_q  [NUM_SLOTS];
  logic [PW-1:0]        coff_q [NUM_SLOTS];
  logic [CW-1:0]        ncached_q, nbacking_q;

  // Request registers
  logic [1:0]                   type_q;
  logic [pbsc_pkg::SizeW-1:0]   size_q;
  logic                         want_q, byoff_q;
  logic [pbsc_pkg::SlotInW-1:0] slotin_q;
  logic [pbsc_pkg::OffW-1:0]    offin_q;

  // Decode results
  logic [SW-1:0] tgt_q;
  logic          tgt_ok_q;
  logic [LW-1:0] tlen_q;
  logic          need_fit_q, miss_q;

  // Search unit
  logic [PW-1:0] pos_q;
  logic [IW-1:0] iter_q;
  logic          done_q, ok_q, ev_tried_q;
  logic          ev_q;
  logic [SW-1:0] eslot_q;
  logic [PW-1:0] eoff_q;

  // Result registers
  logic [1:0]                  st_q;
  logic [pbsc_pkg::SlotOW-1:0] rslot_q;
  logic                        incache_q;
  logic [pbsc_pkg::OffW-1:0]   rcoff_q;
  logic [pbsc_pkg::SizeW-1:0]  rlen_q;
  logic                        hit_q, load_q, evd_q;
  logic [pbsc_pkg::SlotOW-1:0] evslot_q;
  logic [pbsc_pkg::OffW-1:0]   evoff_q;

  // Combinational decode
  logic [LW-1:0] rlen;
  logic          free_any;
  logic [SW-1:0] free_idx;
  logic          offhit_any;
  logic [SW-1:0] offhit_idx;
  logic          slot_ok;
  logic [SW-1:0] slot_idx;
  logic          blk_any;
  logic [SW-1:0] blk_idx;
  logic          cac_any;
  logic [SW-1:0] cac_idx;
  logic [SW-1:0] dec_tgt;
  logic [LW-1:0] dec_tlen;
  logic          dec_ok, dec_fit, dec_miss;

  // Combinational result
  logic [1:0]                  res_status;
  logic [pbsc_pkg::SlotOW-1:0] res_slot;
  logic                        res_in_cache;
  logic [pbsc_pkg::OffW-1:0]   res_coff;
  logic [pbsc_pkg::SizeW-1:0]  res_len;
  logic                        res_hit, res_load;

  assign rlen = LW'((({1'b0, size_q} + LW'(ALIGN_BYTES - 1)) >> AW) << AW);
  assign slot_idx = SW'(slotin_q);
  assign slot_ok  = (slotin_q < pbsc_pkg::SlotInW'(NUM_SLOTS)) && used_q[slot_idx];

  // Priority encoders over the table
  always_comb begin
    free_any = 1'b0; free_idx = '0;
    offhit_any = 1'b0; offhit_idx = '0;
    blk_any = 1'b0; blk_idx = '0;
    cac_any = 1'b0; cac_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1; free_idx = SW'(i);
      end
      if (used_q[i] && cached_q[i] && coff_q[i] == PW'(offin_q)) begin
        offhit_any = 1'b1; offhit_idx = SW'(i);
      end
      if (used_q[i] && cached_q[i] && coff_q[i] < pos_q + PW'(tlen_q) &&
          pos_q < coff_q[i] + PW'(len_q[i])) begin
        blk_any = 1'b1; blk_idx = SW'(i);
      end
      if (used_q[i] && cached_q[i]) begin
        cac_any = 1'b1; cac_idx = SW'(i);
      end
    end
  end

  assign sts_o.need_fit   = need_fit_q;
  assign sts_o.fit_done   = done_q;
  assign sts_o.fit_ok     = ok_q;
  assign sts_o.is_miss    = miss_q;
  assign sts_o.evict_done = ev_tried_q;

  // Target slot, length and placement need for the captured request
  always_comb begin
    dec_tgt = slot_idx; dec_tlen = len_q[slot_idx];
    dec_ok = 1'b0; dec_fit = 1'b0; dec_miss = 1'b0;
    case (type_q)
      pbsc_pkg::REQ_ALLOC: begin
        dec_tgt = free_idx; dec_tlen = rlen;
        dec_ok  = (rlen <= LW'(SLOT_BYTES)) && free_any;
        dec_fit = (rlen <= LW'(SLOT_BYTES)) && free_any && want_q;
      end
      pbsc_pkg::REQ_FREE: begin
        if (byoff_q) begin
          dec_tgt = offhit_idx; dec_tlen = len_q[offhit_idx];
          dec_ok  = offhit_any;
        end else begin
          dec_ok = slot_ok;
        end
      end
      pbsc_pkg::REQ_ACCESS: begin
        dec_ok   = slot_ok;
        dec_fit  = slot_ok && !cached_q[slot_idx];
        dec_miss = slot_ok && !cached_q[slot_idx];
      end
      default: ;
    endcase
  end

  // Request capture and decode
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      type_q <= req_type_i; size_q <= req_size_i; want_q <= want_cache_i;
      byoff_q <= by_offset_i; slotin_q <= slot_in_i; offin_q <= offset_in_i;
    end
    if (cmd_i.decode) begin
      tgt_q <= dec_tgt; tlen_q <= dec_tlen; tgt_ok_q <= dec_ok;
      need_fit_q <= dec_fit; miss_q <= dec_miss;
    end
  end

  // First-fit search: one blocker per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0; ok_q <= 1'b0; ev_tried_q <= 1'b0; ev_q <= 1'b0;
      pos_q <= '0; iter_q <= '0;
    end else begin
      if (cmd_i.decode) begin
        ev_tried_q <= 1'b0; ev_q <= 1'b0; ok_q <= 1'b0;
      end
      if (cmd_i.fit_init) begin
        pos_q <= '0; iter_q <= '0; done_q <= 1'b0; ok_q <= 1'b0;
      end else if (cmd_i.fit_step) begin
        if (!blk_any) begin
          done_q <= 1'b1;
          ok_q <= (pos_q + PW'(tlen_q) <= CacheTop);
        end else if (coff_q[blk_idx] + PW'(len_q[blk_idx]) >= CacheTop ||
                     iter_q == IW'(NUM_SLOTS)) begin
          done_q <= 1'b1;
          ok_q <= 1'b0;
        end else begin
          pos_q <= coff_q[blk_idx] + PW'(len_q[blk_idx]);
          iter_q <= iter_q + 1'b1;
        end
      end
      if (cmd_i.evict) begin
        ev_tried_q <= 1'b1;
        ev_q <= cac_any;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.evict) begin
      eslot_q <= cac_idx; eoff_q <= coff_q[cac_idx];
    end
  end

  // Table and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0; cached_q <= '0; ncached_q <= '0; nbacking_q <= '0;
    end else begin
      if (cmd_i.evict && cac_any) begin
        cached_q[cac_idx] <= 1'b0;
        ncached_q <= ncached_q - 1'b1;
        nbacking_q <= nbacking_q + 1'b1;
      end
      if (cmd_i.commit && tgt_ok_q) begin
        case (type_q)
          pbsc_pkg::REQ_ALLOC: begin
            used_q[tgt_q] <= 1'b1;
            cached_q[tgt_q] <= ok_q;
            if (ok_q) ncached_q <= ncached_q + 1'b1;
            else nbacking_q <= nbacking_q + 1'b1;
          end
          pbsc_pkg::REQ_FREE: begin
            used_q[tgt_q] <= 1'b0;
            cached_q[tgt_q] <= 1'b0;
            if (cached_q[tgt_q]) ncached_q <= ncached_q - 1'b1;
            else nbacking_q <= nbacking_q - 1'b1;
          end
          pbsc_pkg::REQ_ACCESS: begin
            if (miss_q && ok_q) begin
              cached_q[tgt_q] <= 1'b1;
              ncached_q <= ncached_q + 1'b1;
              nbacking_q <= nbacking_q - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && tgt_ok_q) begin
      if (type_q == pbsc_pkg::REQ_ALLOC) begin
        len_q[tgt_q] <= tlen_q;
        coff_q[tgt_q] <= ok_q ? pos_q : '0;
      end else if (type_q == pbsc_pkg::REQ_ACCESS && miss_q && ok_q) begin
        coff_q[tgt_q] <= pos_q;
      end
    end
  end

  // Result fields for the request being committed
  always_comb begin
    res_status = pbsc_pkg::ST_INVALID;
    res_slot = '0; res_in_cache = 1'b0; res_coff = '0; res_len = '0;
    res_hit = 1'b0; res_load = 1'b0;
    case (type_q)
      pbsc_pkg::REQ_ALLOC: begin
        if (rlen <= LW'(SLOT_BYTES)) begin
          if (!tgt_ok_q) res_status = pbsc_pkg::ST_NO_SLOT;
          else begin
            res_status = pbsc_pkg::ST_OK;
            res_slot = pbsc_pkg::SlotOW'(tgt_q);
            res_len = pbsc_pkg::SizeW'(tlen_q);
            res_in_cache = ok_q;
            res_coff = ok_q ? pbsc_pkg::OffW'(pos_q) : '0;
          end
        end
      end
      pbsc_pkg::REQ_FREE: begin
        if (tgt_ok_q) begin
          res_status = pbsc_pkg::ST_OK;
          res_slot = pbsc_pkg::SlotOW'(tgt_q);
          res_len = pbsc_pkg::SizeW'(tlen_q);
        end
      end
      pbsc_pkg::REQ_ACCESS: begin
        if (tgt_ok_q) begin
          res_slot = pbsc_pkg::SlotOW'(tgt_q);
          res_len = pbsc_pkg::SizeW'(tlen_q);
          if (!miss_q) begin
            res_status = pbsc_pkg::ST_OK; res_hit = 1'b1; res_in_cache = 1'b1;
            res_coff = pbsc_pkg::OffW'(coff_q[tgt_q]);
          end else if (ok_q) begin
            res_status = pbsc_pkg::ST_OK; res_in_cache = 1'b1; res_load = 1'b1;
            res_coff = pbsc_pkg::OffW'(pos_q);
          end else begin
            res_status = pbsc_pkg::ST_NO_CACHE;
          end
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      st_q <= res_status; rslot_q <= res_slot; incache_q <= res_in_cache;
      rcoff_q <= res_coff; rlen_q <= res_len; hit_q <= res_hit; load_q <= res_load;
      evd_q <= ev_q;
      evslot_q <= ev_q ? pbsc_pkg::SlotOW'(eslot_q) : '0;
      evoff_q <= ev_q ? pbsc_pkg::OffW'(eoff_q) : '0;
    end
  end

  assign status_o         = st_q;
  assign slot_out_o       = rslot_q;
  assign in_cache_o       = incache_q;
  assign cache_offset_o   = rcoff_q;
  assign length_o         = rlen_q;
  assign hit_o            = hit_q;
  assign load_needed_o    = load_q;
  assign evicted_o        = evd_q;
  assign evicted_slot_o   = evslot_q;
  assign evicted_offset_o = evoff_q;

  assign cached_count_o  = pbsc_pkg::CntW'(ncached_q);
  assign backing_count_o = pbsc_pkg::CntW'(nbacking_q);

`ifndef SYNTHESIS
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncached_q + nbacking_q == CW'($countones(used_q))) else $error("count mismatch");
  a_cached_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cached_q & ~used_q) == '0) else $error("cached slot not in use");
  a_evict_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> !ev_tried_q) else $error("second eviction");
`endif
endmodule
`default_nettype wire
